// ----- rtl/tbff_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbff_pkg: shared types and constants of the boundary face finder
// Face table geometry, entry layout, hash constants, sequencer states and
// the key sort helper.
// ----------------------------------------------------------------------------
package tbff_pkg;

  // Slot count must be a power of two: the home slot is the low hash bits.
  localparam int FACE_SLOTS = 4096;
  localparam int NODE_BITS  = 16;
  localparam int SLOT_BITS  = $clog2(FACE_SLOTS);
  localparam int KEY_BITS   = 3 * NODE_BITS;
  localparam int FIELD_BITS = 16;
  localparam int TAG_BITS   = 16;
  localparam int HASH_BITS  = 32;

  localparam logic [HASH_BITS-1:0] HASH_C0 = 32'h9E3779B1;
  localparam logic [HASH_BITS-1:0] HASH_C1 = 32'h85EBCA77;
  localparam logic [HASH_BITS-1:0] HASH_C2 = 32'hC2B2AE3D;

  localparam logic [1:0] COUNT_ONE = 2'd1;
  localparam logic [1:0] COUNT_MAX = 2'd2;
  localparam logic [1:0] LAST_FACE = 2'd3;

  typedef logic [NODE_BITS-1:0] node_t;
  typedef logic [KEY_BITS-1:0]  key_t;
  typedef logic [SLOT_BITS-1:0] slot_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] count;
    key_t       key;
  } entry_t;

  typedef struct packed {
    logic   rd_en;
    logic   wr_en;
    slot_t  addr;
    entry_t wdata;
  } tbl_req_t;

  typedef struct packed {
    logic  done;
    slot_t slot;
  } hash_res_t;

  typedef enum logic {
    ACT_COUNT = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FACE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_EMIT
  } state_t;

  // Keep the low NODE_BITS of a node number, zero-extend if NODE_BITS is wider.
  function automatic node_t trim_node(input logic [FIELD_BITS-1:0] n);
    logic [NODE_BITS+FIELD_BITS-1:0] w;
    w = {{NODE_BITS{1'b0}}, n};
    return w[NODE_BITS-1:0];
  endfunction

  // Three compare-exchange steps; smallest node lands in the low bits.
  function automatic key_t sort_key(input node_t a, input node_t b, input node_t c);
    node_t k0;
    node_t k1;
    node_t k2;
    node_t t;
    k0 = a;
    k1 = b;
    k2 = c;
    if (k0 > k1) begin t = k0; k0 = k1; k1 = t; end
    if (k1 > k2) begin t = k1; k1 = k2; k2 = t; end
    if (k0 > k1) begin t = k0; k0 = k1; k1 = t; end
    return {k2, k1, k0};
  endfunction

endpackage

// ----- rtl/tbff_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbff_ifs: request and result channels of the boundary face finder
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tbff_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] node_a;
  logic [15:0] node_b;
  logic [15:0] node_c;
  logic [15:0] node_d;
  logic [15:0] element_tag;

  modport source(output valid, action, node_a, node_b, node_c, node_d, element_tag,
                 input ready);
  modport sink(input valid, action, node_a, node_b, node_c, node_d, element_tag,
               output ready);
endinterface

interface tbff_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] tag_echo;
  logic [1:0]  face_number;
  logic        is_boundary;
  logic        table_full;
  logic        last_of_run;

  modport source(output valid, tag_echo, face_number, is_boundary, table_full,
                 last_of_run, input ready);
  modport sink(input valid, tag_echo, face_number, is_boundary, table_full,
               last_of_run, output ready);
endinterface

// ----- rtl/tbff_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbff_hash: multiplicative face key hash
// One 32x32 multiplier, used once per key node in turn; the
// products are folded together by xor into the home slot.
// ----------------------------------------------------------------------------
module tbff_hash
  import tbff_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  key_t      key,
  output hash_res_t res
);

  logic                 busy_r, busy_nxt;
  logic [1:0]           step_r, step_nxt;
  logic [HASH_BITS-1:0] mul_r, mul_nxt;
  logic [HASH_BITS-1:0] h_r, h_nxt;
  logic [HASH_BITS-1:0] op_k;
  logic [HASH_BITS-1:0] op_c;
  logic [HASH_BITS-1:0] h_fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    mul_r <= mul_nxt;
    h_r   <= h_nxt;
  end

  always_comb begin
    op_k = '0;
    op_c = '0;
    case (step_r)
      2'd0:    begin op_k = HASH_BITS'(key[NODE_BITS-1:0]);              op_c = HASH_C0; end
      2'd1:    begin op_k = HASH_BITS'(key[2*NODE_BITS-1:NODE_BITS]);    op_c = HASH_C1; end
      2'd2:    begin op_k = HASH_BITS'(key[3*NODE_BITS-1:2*NODE_BITS]);  op_c = HASH_C2; end
      default: begin op_k = '0;                                          op_c = '0;      end
    endcase
  end

  assign h_fin = h_r ^ mul_r;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    mul_nxt  = mul_r;
    h_nxt    = h_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      h_nxt    = '0;
      mul_nxt  = '0;
    end else if (busy_r) begin
      // fold the previous product, launch the next one
      mul_nxt  = op_k * op_c;
      h_nxt    = h_fin;
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd3) begin
        busy_nxt = 1'b0;
      end
    end
  end

  assign res.done = busy_r && (step_r == 2'd3);
  assign res.slot = h_fin[SLOT_BITS-1:0];

endmodule

// ----- rtl/tbff_face_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbff_face_table: single-ported face table
// One address per cycle, for a read, a write or both; read data registered.
// ----------------------------------------------------------------------------
module tbff_face_table
  import tbff_pkg::*;
(
  input  logic     clk,
  input  tbl_req_t req,
  output entry_t   rd_data
);

  entry_t mem [FACE_SLOTS];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/tetra_boundary_face_finder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tetra_boundary_face_finder_top: tetrahedral mesh boundary face finder
// Counts the faces of each tetrahedron in a hashed, linearly probed table
// and reports per face, on query, whether it belongs to exactly one element.
// ----------------------------------------------------------------------------
// Sequence: per face a key step (ST_FACE), the hash on its shared multiplier
//   (ST_HASH), then a read and a compare (ST_READ, ST_CHECK) on the single
//   table port, again for each extra probe; a query adds ST_EMIT, which waits
//   while the result register is still held. One request at a time.
// Reset: synchronous, active low; then a clearing pass writes every slot
//   in turn, with in_ch.ready low.
// ----------------------------------------------------------------------------
module tetra_boundary_face_finder_top
  import tbff_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  tbff_in_if.sink    in_ch,
  tbff_out_if.source out_ch
);

  state_t        state_r, state_nxt;
  logic [1:0]    face_r, face_nxt;
  logic          action_r, action_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  node_t         node_r [4];
  node_t         node_nxt [4];
  key_t          key_r, key_nxt;
  slot_t         slot_r, slot_nxt;
  slot_t         probes_r, probes_nxt;
  slot_t         clr_r, clr_nxt;
  logic          overflow_r, overflow_nxt;
  logic          bnd_r, bnd_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [TAG_BITS-1:0] out_tag_r, out_tag_nxt;
  logic [1:0]          out_face_r, out_face_nxt;
  logic                out_bnd_r, out_bnd_nxt;
  logic                out_full_r, out_full_nxt;
  logic                out_last_r, out_last_nxt;

  tbl_req_t  tbl_req;
  entry_t    tbl_rd;
  hash_res_t hash_res;
  logic      hash_start;
  key_t      face_key;
  logic      in_fire;

  localparam slot_t SLOT_LAST = SLOT_BITS'(FACE_SLOTS - 1);

  tbff_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (key_r),
    .res   (hash_res)
  );

  tbff_face_table u_table (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (tbl_rd)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // face n leaves out corner n
  always_comb begin
    case (face_r)
      2'd0:    face_key = sort_key(node_r[1], node_r[2], node_r[3]);
      2'd1:    face_key = sort_key(node_r[0], node_r[2], node_r[3]);
      2'd2:    face_key = sort_key(node_r[0], node_r[1], node_r[3]);
      default: face_key = sort_key(node_r[0], node_r[1], node_r[2]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
    end
    face_r     <= face_nxt;
    action_r   <= action_nxt;
    tag_r      <= tag_nxt;
    node_r     <= node_nxt;
    key_r      <= key_nxt;
    slot_r     <= slot_nxt;
    probes_r   <= probes_nxt;
    bnd_r      <= bnd_nxt;
    out_tag_r  <= out_tag_nxt;
    out_face_r <= out_face_nxt;
    out_bnd_r  <= out_bnd_nxt;
    out_full_r <= out_full_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    face_nxt      = face_r;
    action_nxt    = action_r;
    tag_nxt       = tag_r;
    node_nxt      = node_r;
    key_nxt       = key_r;
    slot_nxt      = slot_r;
    probes_nxt    = probes_r;
    clr_nxt       = clr_r;
    overflow_nxt  = overflow_r;
    bnd_nxt       = bnd_r;
    out_valid_nxt = out_valid_r;
    out_tag_nxt   = out_tag_r;
    out_face_nxt  = out_face_r;
    out_bnd_nxt   = out_bnd_r;
    out_full_nxt  = out_full_r;
    out_last_nxt  = out_last_r;
    tbl_req       = '0;
    hash_start    = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        tbl_req.wr_en = 1'b1;
        tbl_req.addr  = clr_r;
        tbl_req.wdata = '0;
        clr_nxt       = clr_r + 1'b1;
        if (clr_r == SLOT_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          action_nxt  = in_ch.action;
          tag_nxt     = in_ch.element_tag;
          node_nxt[0] = trim_node(in_ch.node_a);
          node_nxt[1] = trim_node(in_ch.node_b);
          node_nxt[2] = trim_node(in_ch.node_c);
          node_nxt[3] = trim_node(in_ch.node_d);
          face_nxt    = '0;
          state_nxt   = ST_FACE;
        end
      end

      ST_FACE: begin
        key_nxt    = face_key;
        probes_nxt = '0;
        hash_start = 1'b1;
        state_nxt  = ST_HASH;
      end

      ST_HASH: begin
        if (hash_res.done) begin
          slot_nxt  = hash_res.slot;
          state_nxt = ST_READ;
        end
      end

      ST_READ: begin
        tbl_req.rd_en = 1'b1;
        tbl_req.addr  = slot_r;
        state_nxt     = ST_CHECK;
      end

      ST_CHECK: begin
        bnd_nxt = 1'b0;
        if (!tbl_rd.valid) begin
          // free slot: the key is absent
          if (action_r == ACT_COUNT) begin
            tbl_req.wr_en       = 1'b1;
            tbl_req.addr        = slot_r;
            tbl_req.wdata.valid = 1'b1;
            tbl_req.wdata.count = COUNT_ONE;
            tbl_req.wdata.key   = key_r;
          end
        end else if (tbl_rd.key == key_r) begin
          if (action_r == ACT_COUNT) begin
            if (tbl_rd.count < COUNT_MAX) begin
              tbl_req.wr_en       = 1'b1;
              tbl_req.addr        = slot_r;
              tbl_req.wdata.valid = 1'b1;
              tbl_req.wdata.count = tbl_rd.count + 2'd1;
              tbl_req.wdata.key   = key_r;
            end
          end else begin
            bnd_nxt = (tbl_rd.count == COUNT_ONE);
          end
        end else if (probes_r == SLOT_LAST) begin
          // every slot taken by another key: drop it
          if (action_r == ACT_COUNT) begin
            overflow_nxt = 1'b1;
          end
        end

        if (tbl_rd.valid && (tbl_rd.key != key_r) && (probes_r != SLOT_LAST)) begin
          slot_nxt   = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
          probes_nxt = probes_r + 1'b1;
          state_nxt  = ST_READ;
        end else if (action_r == ACT_QUERY) begin
          state_nxt = ST_EMIT;
        end else if (face_r == LAST_FACE) begin
          state_nxt = ST_IDLE;
        end else begin
          face_nxt  = face_r + 2'd1;
          state_nxt = ST_FACE;
        end
      end

      ST_EMIT: begin
        // hold until the result register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_tag_nxt   = tag_r;
          out_face_nxt  = face_r;
          out_bnd_nxt   = bnd_r;
          out_full_nxt  = overflow_r;
          out_last_nxt  = (face_r == LAST_FACE);
          if (face_r == LAST_FACE) begin
            state_nxt = ST_IDLE;
          end else begin
            face_nxt  = face_r + 2'd1;
            state_nxt = ST_FACE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.tag_echo    = out_tag_r;
  assign out_ch.face_number = out_face_r;
  assign out_ch.is_boundary = out_bnd_r;
  assign out_ch.table_full  = out_full_r;
  assign out_ch.last_of_run = out_last_r;

endmodule

// ----- rtl/tbff_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbff_checker: port-level checks of the boundary face finder
// Watches the request and result channels and flags misbehavior.
// ----------------------------------------------------------------------------
module tbff_checker
  import tbff_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_face,
  input logic       out_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one request at a time: busy right after a request moves
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // table clearing keeps the block closed after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("ready during table clearing");

  // the last result of a run is the one for the last face
  a_last_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_face == LAST_FACE)))
    else $error("last_of_run does not match face number");

endmodule

bind tetra_boundary_face_finder_top tbff_checker u_tbff_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_face  (out_ch.face_number),
  .out_last  (out_ch.last_of_run)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the tetrahedral boundary face finder
// Runs count and query requests through the block, with directed corner
// cases followed by random element sequences under varying backpressure. An
// in-bench face table predicts every query result.
// ----------------------------------------------------------------------------
module tb
  import tbff_pkg::*;
();

  localparam int STUCK_LIMIT = 150000;
  localparam int HOLD_CYCLES = 400;
  localparam int POOL_DEPTH  = 24;

  typedef logic [3:0][15:0] quad_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [1:0]          face;
    logic                boundary;
    logic                full;
    logic                last;
  } face_result_t;

  class face_scoreboard;
    bit           slot_valid [FACE_SLOTS];
    bit [1:0]     slot_count [FACE_SLOTS];
    key_t         slot_key   [FACE_SLOTS];
    bit           overflow;
    int           errors;
    face_result_t awaited [$];

    // Face f leaves out corner f; smallest node goes to the low bits.
    function key_t face_key(quad_t q, int f);
      node_t k [3];
      node_t t;
      int    j;
      j = 0;
      for (int c = 0; c < 4; c++) begin
        if (c != f) begin
          k[j] = q[c][NODE_BITS-1:0];
          j++;
        end
      end
      if (k[0] > k[1]) begin t = k[0]; k[0] = k[1]; k[1] = t; end
      if (k[1] > k[2]) begin t = k[1]; k[1] = k[2]; k[2] = t; end
      if (k[0] > k[1]) begin t = k[0]; k[0] = k[1]; k[1] = t; end
      return {k[2], k[1], k[0]};
    endfunction

    function slot_t home_slot(key_t key);
      logic [HASH_BITS-1:0] h;
      h = (HASH_C0 * 32'(key[NODE_BITS-1:0])) ^
          (HASH_C1 * 32'(key[2*NODE_BITS-1:NODE_BITS])) ^
          (HASH_C2 * 32'(key[KEY_BITS-1:2*NODE_BITS]));
      return h[SLOT_BITS-1:0];
    endfunction

    // Linear probe: slot holding the key, else first free slot, else FACE_SLOTS.
    function int find_slot(key_t key, output bit hit);
      int s;
      s = home_slot(key);
      hit = 1'b0;
      for (int n = 0; n < FACE_SLOTS; n++) begin
        if (!slot_valid[s]) return s;
        if (slot_key[s] == key) begin
          hit = 1'b1;
          return s;
        end
        s = (s + 1) % FACE_SLOTS;
      end
      return FACE_SLOTS;
    endfunction

    function void note_request(action_t act, quad_t q, logic [TAG_BITS-1:0] tag);
      key_t         key;
      int           s;
      bit           hit;
      face_result_t r;
      for (int f = 0; f < 4; f++) begin
        key = face_key(q, f);
        s = find_slot(key, hit);
        if (act == ACT_COUNT) begin
          if (hit) begin
            if (slot_count[s] < COUNT_MAX) slot_count[s]++;
          end else if (s < FACE_SLOTS) begin
            slot_valid[s] = 1'b1;
            slot_key[s]   = key;
            slot_count[s] = COUNT_ONE;
          end else begin
            overflow = 1'b1;
          end
        end else begin
          r.tag      = tag;
          r.face     = 2'(f);
          r.boundary = hit && (slot_count[s] == COUNT_ONE);
          r.full     = overflow;
          r.last     = (2'(f) == LAST_FACE);
          awaited.push_back(r);
        end
      end
    endfunction

    function void check_result(face_result_t got);
      face_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: face result with none expected: got tag=%h face=%0d bnd=%b full=%b last=%b",
                 $time, got.tag, got.face, got.boundary, got.full, got.last);
        return;
      end
      want = awaited.pop_front();
      if (got.tag !== want.tag || got.face !== want.face || got.boundary !== want.boundary ||
          got.full !== want.full || got.last !== want.last) begin
        errors++;
        $display("%0t: face result mismatch: expected tag=%h face=%0d bnd=%b full=%b last=%b",
                 $time, want.tag, want.face, want.boundary, want.full, want.last);
        $display("%0t:                        got      tag=%h face=%0d bnd=%b full=%b last=%b",
                 $time, got.tag, got.face, got.boundary, got.full, got.last);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tbff_in_if  in_if ();
  tbff_out_if out_if ();

  tetra_boundary_face_finder_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  face_scoreboard sb = new();

  int    idle_pct;
  int    stall_pct;
  int    hold_req;
  int    hold_seen;
  int    hold_left;
  int    stuck_cycles;
  quad_t pool [$];

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      out_if.ready <= 1'b0;
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result('{tag: out_if.tag_echo, face: out_if.face_number,
                        boundary: out_if.is_boundary, full: out_if.table_full,
                        last: out_if.last_of_run});
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic quad_t quad_of(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                    logic [15:0] d);
    return {d, c, b, a};
  endfunction

  // Tiny node numbers three times in ten so faces get shared, extremes once in ten, rest anywhere.
  function automatic logic [15:0] rand_node();
    case ($urandom_range(9))
      0, 1, 2: return 16'($urandom_range(15));
      3:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic quad_t random_quad();
    quad_t q;
    for (int c = 0; c < 4; c++) q[c] = rand_node();
    return q;
  endfunction

  function automatic void remember(quad_t q);
    pool.push_back(q);
    if (pool.size() > POOL_DEPTH) void'(pool.pop_front());
  endfunction

  task automatic send_request(action_t act, quad_t q, logic [TAG_BITS-1:0] tag);
    int gap;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 48);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.action      <= act;
    in_if.node_a      <= q[0];
    in_if.node_b      <= q[1];
    in_if.node_c      <= q[2];
    in_if.node_d      <= q[3];
    in_if.element_tag <= tag;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(act, q, tag);
  endtask

  // Drop the request line and hold off until every result is back.
  task automatic wait_drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Elements are mostly revisited from a small pool so counts build up.
  task automatic random_request();
    quad_t q;
    int    r;
    int    c;
    r = $urandom_range(99);
    if (pool.size() == 0 || r < 20) begin
      q = random_quad();
      remember(q);
      send_request(ACT_COUNT, q, 16'($urandom));
    end else if (r < 40) begin
      // neighbor: keep one face of a known element, move the opposite corner
      q = pool[$urandom_range(pool.size() - 1)];
      c = $urandom_range(3);
      q[c] = rand_node();
      remember(q);
      send_request(ACT_COUNT, q, 16'($urandom));
    end else if (r < 48) begin
      q = pool[$urandom_range(pool.size() - 1)];
      send_request(ACT_COUNT, q, 16'($urandom));
    end else if (r < 90) begin
      q = pool[$urandom_range(pool.size() - 1)];
      send_request(ACT_QUERY, q, 16'($urandom));
    end else begin
      send_request(action_t'($urandom_range(1)), random_quad(), 16'($urandom));
    end
  endtask

  task automatic run_phase(int n, int idle, int stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) random_request();
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.action       <= ACT_COUNT;
    in_if.node_a       <= '0;
    in_if.node_b       <= '0;
    in_if.node_c       <= '0;
    in_if.node_d       <= '0;
    in_if.element_tag  <= '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: every face unknown
    send_request(ACT_QUERY, quad_of(0, 0, 0, 0), 16'h0000);
    send_request(ACT_COUNT, quad_of(1, 2, 3, 4), 16'hFFFF);
    send_request(ACT_QUERY, quad_of(1, 2, 3, 4), 16'hFFFF);
    // shares face (1,2,3), listed in another order
    send_request(ACT_COUNT, quad_of(2, 1, 3, 5), 16'h0001);
    send_request(ACT_QUERY, quad_of(1, 2, 3, 4), 16'h0002);
    send_request(ACT_QUERY, quad_of(2, 1, 3, 5), 16'h0003);
    // counted again: shared face saturates at two
    send_request(ACT_COUNT, quad_of(1, 2, 3, 4), 16'h8000);
    send_request(ACT_QUERY, quad_of(1, 2, 3, 4), 16'h7FFF);
    // repeated node numbers
    send_request(ACT_COUNT, quad_of(7, 7, 7, 7), 16'h0004);
    send_request(ACT_QUERY, quad_of(7, 7, 7, 7), 16'h0005);
    send_request(ACT_COUNT, quad_of(9, 9, 10, 11), 16'h0006);
    send_request(ACT_QUERY, quad_of(9, 9, 10, 11), 16'h0007);
    // top of the node range, queried with corners reversed
    send_request(ACT_COUNT, quad_of(16'hFFFF, 16'hFFFE, 16'hFFFD, 16'hFFFC), 16'hAAAA);
    send_request(ACT_QUERY, quad_of(16'hFFFC, 16'hFFFD, 16'hFFFE, 16'hFFFF), 16'h5555);
    send_request(ACT_COUNT, quad_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 0), 16'h00FF);
    send_request(ACT_QUERY, quad_of(0, 16'hFFFF, 16'hFFFF, 16'hFFFF), 16'hFF00);
    send_request(ACT_QUERY, quad_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 16'hFFFF);

    run_phase(95, 0, 0);

    // long receiver hold-off while requests keep coming, then let it drain
    hold_req++;
    repeat (12) send_request(ACT_QUERY, pool[$urandom_range(pool.size() - 1)], 16'($urandom));
    wait_drain();

    run_phase(95, 63, 0);
    run_phase(95, 0, 63);
    run_phase(95, 17, 17);

    wait_drain();
    repeat (64) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
